// ----- hw/rtl/blt_pkg.sv -----
// Package for the block list text buffer: sizes, widths, codes and payload types.
// No dependencies; blt_cell and the top level import it.
package blt_pkg;

  localparam int MAX_BLOCKS     = 64;
  localparam int BLOCK_CAPACITY = 64;

  localparam int POS_W   = 13;
  localparam int CHAR_W  = 8;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 7;
  localparam int LC_W    = 13;

  localparam int BLK_W   = $clog2(MAX_BLOCKS);
  localparam int NB_W    = $clog2(MAX_BLOCKS + 1);
  localparam int SIZE_W  = $clog2(BLOCK_CAPACITY + 1);
  localparam int OFF_W   = $clog2(BLOCK_CAPACITY);
  localparam int SUM_W   = $clog2(MAX_BLOCKS * BLOCK_CAPACITY + 1);
  localparam int CMP_W   = (SUM_W > POS_W) ? SUM_W : POS_W;
  localparam int STORE_DEPTH = MAX_BLOCKS * BLOCK_CAPACITY;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int DIVC_W  = $clog2(LC_W + 1);

  localparam logic [LC_W-1:0] LOAD_COUNT_MAX = LC_W'(8191);

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INS   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  localparam logic REG_BLOCKS = 1'b0;
  localparam logic REG_FILL   = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] character;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character_res;
    logic [STAT_W-1:0] status;
  } out_t;

  typedef struct packed {
    logic shift;
    logic add;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/blt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module blt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/blt_cell.sv -----
// One cell of the block size ring: holds the size of one block and passes it on.
// Depends on blt_pkg.
module blt_cell import blt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [SIZE_W-1:0] din,
  output logic [SIZE_W-1:0] q
);

  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] size_nxt;

  always_comb begin
    size_nxt = size_r;
    if (ctl.shift) begin
      size_nxt = din + SIZE_W'(ctl.add);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else begin
      size_r <= size_nxt;
    end
  end

  assign q = size_r;

endmodule

// ----- hw/rtl/block_list_text_buffer_top.sv -----
// Top level of the block list text buffer: controller, size ring and character store.
// Depends on blt_pkg, blt_cell and blt_ram.
//
// The block sizes live in a ring of MAX_BLOCKS cells that rotates once per item that
// reaches the walk, one cell per cycle. Around the walk every item is accepted, then
// its outcome is decided and the result register is loaded. A load adds a bit-serial
// division of LC_W quotient bits ahead of the walk. When the position is found, a
// query adds a store read, and an insert into a block with room adds a write plus a
// store read and then a write for each character moved in its block, at most
// BLOCK_CAPACITY - 1 of them. Items are taken one at a time. A zero position, a load
// when the load count is exhausted or an unused mode skips the walk, as does a load
// whose block index is not below the block count. A finished result waits in the
// output register while the next item is accepted.
module block_list_text_buffer_top import blt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV  = 4'd1;
  localparam logic [3:0] ST_SCAN = 4'd2;
  localparam logic [3:0] ST_POST = 4'd3;
  localparam logic [3:0] ST_QWT  = 4'd4;
  localparam logic [3:0] ST_SHRD = 4'd5;
  localparam logic [3:0] ST_SHWR = 4'd6;
  localparam logic [3:0] ST_DONE = 4'd7;

  logic [3:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  blocks_r, blocks_nxt;
  logic [CFG_W-1:0]  fill_r, fill_nxt;
  logic [LC_W-1:0]   load_count_r, load_count_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CHAR_W-1:0] chr_r, chr_nxt;
  logic [BLK_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  before_r, before_nxt;
  logic              found_r, found_nxt;
  logic [BLK_W-1:0]  blk_r, blk_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [OFF_W-1:0]  i_r, i_nxt;
  logic [OFF_W-1:0]  local_r, local_nxt;
  logic [LC_W-1:0]   q_r, q_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [DIVC_W-1:0] divc_r, divc_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [CHAR_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic [NB_W-1:0]   nb_eff;
  logic [SIZE_W-1:0] fill_eff;
  logic [SIZE_W:0]   rem_sh;
  logic [SIZE_W:0]   rem_sub;
  logic [CMP_W-1:0]  scan_sum;
  logic [CMP_W-1:0]  local_full;
  logic [ADDR_W-1:0] base;

  logic              ring_shift;
  logic              ring_add;
  logic [SIZE_W-1:0] cell_q [MAX_BLOCKS];
  logic [SIZE_W-1:0] head;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  logic              cfg_wr;

  // Block size ring; the head cell feeds the tail, with an optional increment.
  assign head = cell_q[0];

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    cell_ctl_t         ctl_g;
    logic [SIZE_W-1:0] din_g;
    if (g == MAX_BLOCKS - 1) begin : g_tail
      assign ctl_g = '{shift: ring_shift, add: ring_add};
      assign din_g = head;
    end else begin : g_mid
      assign ctl_g = '{shift: ring_shift, add: 1'b0};
      assign din_g = cell_q[g+1];
    end
    blt_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl_g),
      .din  (din_g),
      .q    (cell_q[g])
    );
  end

  blt_ram #(.WIDTH(CHAR_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    prdata = 32'(blocks_r);
    if (paddr[2] == REG_FILL) begin
      prdata = 32'(fill_r);
    end
  end

  always_comb begin
    nb_eff = NB_W'(blocks_r);
    if (blocks_r == '0) begin
      nb_eff = NB_W'(1);
    end else if (32'(blocks_r) > 32'(MAX_BLOCKS)) begin
      nb_eff = NB_W'(MAX_BLOCKS);
    end
    fill_eff = SIZE_W'(fill_r);
    if (fill_r == '0) begin
      fill_eff = SIZE_W'(1);
    end else if (32'(fill_r) > 32'(BLOCK_CAPACITY)) begin
      fill_eff = SIZE_W'(BLOCK_CAPACITY);
    end
  end

  assign rem_sh     = {rem_r, q_r[LC_W-1]};
  assign rem_sub    = rem_sh - {1'b0, fill_eff};
  assign scan_sum   = CMP_W'(sum_r) + CMP_W'(head);
  assign local_full = CMP_W'(pos_r) - CMP_W'(before_r) - CMP_W'(1);
  assign base       = ADDR_W'(blk_r) * ADDR_W'(BLOCK_CAPACITY);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    blocks_nxt     = blocks_r;
    fill_nxt       = fill_r;
    load_count_nxt = load_count_r;
    mode_nxt       = mode_r;
    pos_nxt        = pos_r;
    chr_nxt        = chr_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    before_nxt     = before_r;
    found_nxt      = found_r;
    blk_nxt        = blk_r;
    size_nxt       = size_r;
    i_nxt          = i_r;
    local_nxt      = local_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    divc_nxt       = divc_r;
    status_nxt     = status_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    ring_shift     = 1'b0;
    ring_add       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = base + ADDR_W'(i_r);
    ram_wdata      = ram_rdata;
    ram_raddr      = base + ADDR_W'(i_r - OFF_W'(1));

    if (cfg_wr) begin
      if (paddr[2] == REG_BLOCKS) begin
        blocks_nxt = pwdata[CFG_W-1:0];
      end else begin
        fill_nxt = pwdata[CFG_W-1:0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_data.mode;
          pos_nxt    = in_data.position;
          chr_nxt    = in_data.character;
          res_nxt    = '0;
          status_nxt = STAT_OK;
          cnt_nxt    = '0;
          sum_nxt    = '0;
          found_nxt  = 1'b0;
          case (in_data.mode)
            MODE_LOAD: begin
              if (load_count_r >= LOAD_COUNT_MAX) begin
                status_nxt = STAT_FULL;
                state_nxt  = ST_DONE;
              end else begin
                q_nxt     = load_count_r;
                rem_nxt   = '0;
                divc_nxt  = '0;
                state_nxt = ST_DIV;
              end
            end
            MODE_INS, MODE_QUERY: begin
              if (in_data.position == '0) begin
                status_nxt = STAT_RANGE;
                state_nxt  = ST_DONE;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_sh >= {1'b0, fill_eff}) begin
          rem_nxt = rem_sub[SIZE_W-1:0];
          q_nxt   = {q_r[LC_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[SIZE_W-1:0];
          q_nxt   = {q_r[LC_W-2:0], 1'b0};
        end
        divc_nxt = divc_r + DIVC_W'(1);
        if (divc_r == DIVC_W'(LC_W - 1)) begin
          if (q_nxt >= LC_W'(nb_eff)) begin
            status_nxt = STAT_FULL;
            state_nxt  = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ring_shift = 1'b1;
        cnt_nxt = cnt_r + BLK_W'(1);
        if (mode_r == MODE_LOAD) begin
          if (LC_W'(cnt_r) == q_r) begin
            found_nxt = 1'b1;
            blk_nxt   = cnt_r;
            size_nxt  = head;
            ring_add  = (32'(head) < 32'(BLOCK_CAPACITY));
          end
        end else if (!found_r && (NB_W'(cnt_r) < nb_eff)) begin
          sum_nxt = SUM_W'(scan_sum);
          if (scan_sum >= CMP_W'(pos_r)) begin
            found_nxt  = 1'b1;
            blk_nxt    = cnt_r;
            before_nxt = sum_r;
            size_nxt   = head;
            ring_add   = (mode_r == MODE_INS) && (32'(head) < 32'(BLOCK_CAPACITY));
          end
        end
        if (cnt_r == BLK_W'(MAX_BLOCKS - 1)) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        local_nxt = local_full[OFF_W-1:0];
        i_nxt     = size_r[OFF_W-1:0];
        ram_raddr = base + ADDR_W'(local_full[OFF_W-1:0]);
        state_nxt = ST_DONE;
        if (mode_r == MODE_LOAD) begin
          if (32'(size_r) >= 32'(BLOCK_CAPACITY)) begin
            status_nxt = STAT_FULL;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = base + ADDR_W'(size_r[OFF_W-1:0]);
            ram_wdata      = chr_r;
            load_count_nxt = load_count_r + LC_W'(1);
          end
        end else if (!found_r) begin
          status_nxt = STAT_RANGE;
        end else if (mode_r == MODE_QUERY) begin
          state_nxt = ST_QWT;
        end else if (32'(size_r) >= 32'(BLOCK_CAPACITY)) begin
          status_nxt = STAT_FULL;
        end else begin
          state_nxt = ST_SHRD;
        end
      end
      ST_QWT: begin
        res_nxt   = ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_SHRD: begin
        if (i_r > local_r) begin
          state_nxt = ST_SHWR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = base + ADDR_W'(local_r);
          ram_wdata = chr_r;
          state_nxt = ST_DONE;
        end
      end
      ST_SHWR: begin
        // Read data from the previous cycle moves up one place.
        ram_we    = 1'b1;
        i_nxt     = i_r - OFF_W'(1);
        state_nxt = ST_SHRD;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{character_res: res_r, status: status_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      blocks_r     <= CFG_W'(64);
      fill_r       <= CFG_W'(64);
      load_count_r <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      blocks_r     <= blocks_nxt;
      fill_r       <= fill_nxt;
      load_count_r <= load_count_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    pos_r      <= pos_nxt;
    chr_r      <= chr_nxt;
    sum_r      <= sum_nxt;
    before_r   <= before_nxt;
    found_r    <= found_nxt;
    blk_r      <= blk_nxt;
    size_r     <= size_nxt;
    i_r        <= i_nxt;
    local_r    <= local_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    divc_r     <= divc_nxt;
    status_r   <= status_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // The ring must make exactly one full turn per scan.
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && cnt_r == BLK_W'(MAX_BLOCKS - 1)) |=> (state_r == ST_POST))
    else $error("size ring scan did not end after one turn");

  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r == '0))
    else $error("ring position lost between transactions");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHWR) |-> (i_r > local_r))
    else $error("character move below the insert point");

  a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && out_stall) |=> (state_r == ST_DONE))
    else $error("result dropped while output slot was held");
`endif

endmodule
